// File: hw/rtl/stdf_pkg.sv
// ============================================================================
// stdf_pkg: shared types and constants of the telegram deframer
// Window layout, queue command format and header pattern constants.
// ============================================================================
`default_nettype none

package stdf_pkg;

    localparam int HDR_BYTES  = 14;
    localparam int ZERO_BYTES = 6;
    localparam int CNT_W      = $clog2(HDR_BYTES + 1);
    localparam int REM_W      = 18;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // Fixed bytes that follow the length word in a header.
    localparam logic [7:0] SYNC_B8  = 8'hFF;
    localparam logic [7:0] SYNC_B9  = 8'h07;
    localparam logic [7:0] SYNC_B10 = 8'h02;
    localparam logic [7:0] SYNC_B11 = 8'h01;
    localparam logic [7:0] SYNC_B12 = 8'h00;
    localparam logic [7:0] SYNC_B13 = 8'h00;

    // Index 0 holds the oldest byte.
    typedef logic [HDR_BYTES-1:0][7:0] stdf_win_t;

    // One command for the back end: emit cnt bytes from data, lowest first.
    typedef struct packed {
        stdf_win_t        data;
        logic [CNT_W-1:0] cnt;
        logic             first;
        logic             last;
    } stdf_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } stdf_q_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/stdf_front.sv
// ============================================================================
// stdf_front: header search and pass-through classification
// Keeps the sliding search window, detects headers and turns every accepted
// byte that belongs to a telegram into a command for the back end.
// ============================================================================
`default_nettype none

module stdf_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,
    input  wire stdf_pkg::stdf_q_stat_t q_stat,
    output logic                      push,
    output stdf_pkg::stdf_cmd_t       push_cmd
);
    import stdf_pkg::*;

    stdf_win_t        win_reg, win_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             passing_reg, passing_next;
    logic [REM_W-1:0] rem_reg, rem_next;

    stdf_win_t        w_in;
    stdf_win_t        w_short;
    logic             accept;
    logic             full_after;
    logic             match;
    logic [15:0]      word;
    logic [16:0]      word_p2;
    logic [REM_W-1:0] tel_len;
    logic             is_long;
    logic [CNT_W-1:0] n_short;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && !q_stat.full;

    always_comb begin
        // Window after the new byte is appended (oldest dropped when full).
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (fill_reg == CNT_W'(HDR_BYTES)) begin
                w_in[i] = (i == HDR_BYTES - 1) ? s_tdata : win_reg[(i + 1) % HDR_BYTES];
            end else begin
                w_in[i] = (CNT_W'(i) == fill_reg) ? s_tdata : win_reg[i];
            end
        end

        full_after = (fill_reg == CNT_W'(HDR_BYTES)) || (fill_reg == CNT_W'(HDR_BYTES - 1));

        match = full_after &&
                (w_in[8] == SYNC_B8) && (w_in[9] == SYNC_B9) &&
                (w_in[10] == SYNC_B10) && (w_in[11] == SYNC_B11) &&
                (w_in[12] == SYNC_B12) && (w_in[13] == SYNC_B13);
        for (int i = 0; i < ZERO_BYTES; i++) begin
            if (w_in[i] != 8'h00) begin
                match = 1'b0;
            end
        end

        word    = {w_in[6], w_in[7]};
        word_p2 = {1'b0, word} + 17'd2;
        tel_len = {word_p2, 1'b0};
        is_long = tel_len >= REM_W'(HDR_BYTES);
        n_short = tel_len[CNT_W-1:0];

        // A short telegram leaves the rest of the window at its front.
        for (int i = 0; i < HDR_BYTES; i++) begin
            w_short[i] = 8'h00;
            for (int j = 0; j < HDR_BYTES; j++) begin
                if (j == i + int'(n_short)) begin
                    w_short[i] = w_in[j];
                end
            end
        end
    end

    always_comb begin
        win_next     = win_reg;
        fill_next    = fill_reg;
        passing_next = passing_reg;
        rem_next     = rem_reg;
        push         = 1'b0;
        push_cmd     = '0;

        if (accept) begin
            if (passing_reg) begin
                push              = 1'b1;
                push_cmd.data[0]  = s_tdata;
                push_cmd.cnt      = CNT_W'(1);
                push_cmd.first    = 1'b0;
                push_cmd.last     = rem_reg <= REM_W'(1);
                if (rem_reg <= REM_W'(1)) begin
                    rem_next     = '0;
                    passing_next = 1'b0;
                end else begin
                    rem_next = rem_reg - REM_W'(1);
                end
            end else if (match) begin
                push           = 1'b1;
                push_cmd.data  = w_in;
                push_cmd.first = 1'b1;
                push_cmd.last  = tel_len <= REM_W'(HDR_BYTES);
                if (is_long) begin
                    push_cmd.cnt = CNT_W'(HDR_BYTES);
                    rem_next     = tel_len - REM_W'(HDR_BYTES);
                    passing_next = tel_len != REM_W'(HDR_BYTES);
                    win_next     = '0;
                    fill_next    = '0;
                end else begin
                    push_cmd.cnt = n_short;
                    win_next     = w_short;
                    fill_next    = CNT_W'(HDR_BYTES) - n_short;
                end
            end else begin
                win_next  = w_in;
                fill_next = full_after ? CNT_W'(HDR_BYTES) : fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            fill_reg    <= '0;
            passing_reg <= 1'b0;
            rem_reg     <= '0;
        end else begin
            win_reg     <= win_next;
            fill_reg    <= fill_next;
            passing_reg <= passing_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stdf_queue.sv
// ============================================================================
// stdf_queue: command queue between front and back end
// A small register FIFO that lets the search side and the output side stall
// independently of each other.
// ============================================================================
`default_nettype none

module stdf_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire stdf_pkg::stdf_cmd_t  push_cmd,
    input  wire logic                 pop,
    output stdf_pkg::stdf_cmd_t       pop_cmd,
    output stdf_pkg::stdf_q_stat_t    q_stat
);
    import stdf_pkg::*;

    stdf_cmd_t          mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign pop_cmd      = mem_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign q_stat.empty = count_reg == '0;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stdf_back.sv
// ============================================================================
// stdf_back: telegram byte emitter
// Takes commands from the queue and sends their bytes one per transaction,
// with first and last marks, from a registered shift stage.
// ============================================================================
`default_nettype none

module stdf_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire stdf_pkg::stdf_q_stat_t q_stat,
    input  wire stdf_pkg::stdf_cmd_t   pop_cmd,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);
    import stdf_pkg::*;

    logic             cur_valid_reg, cur_valid_next;
    stdf_win_t        cur_data_reg, cur_data_next;
    logic [CNT_W-1:0] cur_rem_reg, cur_rem_next;
    logic             cur_first_reg, cur_first_next;
    logic             cur_last_reg, cur_last_next;

    logic             xfer;
    logic             done;

    assign m_tvalid = cur_valid_reg;
    assign m_tdata  = cur_data_reg[0];
    assign m_tuser  = cur_first_reg;
    assign m_tlast  = cur_last_reg && (cur_rem_reg == CNT_W'(1));

    assign xfer = cur_valid_reg && m_tready;
    // The stage is free when empty or when its final byte leaves this cycle.
    assign done = !cur_valid_reg || (xfer && cur_rem_reg == CNT_W'(1));
    assign pop  = done && !q_stat.empty;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_data_next  = cur_data_reg;
        cur_rem_next   = cur_rem_reg;
        cur_first_next = cur_first_reg;
        cur_last_next  = cur_last_reg;

        if (pop) begin
            cur_valid_next = 1'b1;
            cur_data_next  = pop_cmd.data;
            cur_rem_next   = pop_cmd.cnt;
            cur_first_next = pop_cmd.first;
            cur_last_next  = pop_cmd.last;
        end else if (done) begin
            cur_valid_next = 1'b0;
        end else if (xfer) begin
            for (int i = 0; i < HDR_BYTES - 1; i++) begin
                cur_data_next[i] = cur_data_reg[i + 1];
            end
            cur_data_next[HDR_BYTES-1] = 8'h00;
            cur_rem_next   = cur_rem_reg - CNT_W'(1);
            cur_first_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            cur_rem_reg   <= '0;
            cur_first_reg <= 1'b0;
            cur_last_reg  <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            cur_rem_reg   <= cur_rem_next;
            cur_first_reg <= cur_first_next;
            cur_last_reg  <= cur_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_data_reg <= cur_data_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/scanner_telegram_deframer.sv
// Path: a passed byte is held in the queue, then in the output stage, before m_tdata.
// Throughput: one input byte per cycle while the queue has room; a header match emits
// 4 to 14 bytes, one per cycle while m_tready is high, and the four-entry command queue
// takes up to four more commands during that burst before s_tready drops.
// Sustained rate is set by the output port, one byte per cycle.
// Reset: synchronous active-low aresetn empties the window, queue and output stage.
// ============================================================================
// scanner_telegram_deframer: serial telegram deframer, top level
// Searches the byte stream for telegram headers and forwards whole telegrams
// with first and last marks.
// ============================================================================
`default_nettype none

module scanner_telegram_deframer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] tel_byte
    output logic            m_tuser,   // [0] tel_first
    output logic            m_tlast    // tel_last
);
    import stdf_pkg::*;

    stdf_q_stat_t q_stat;
    stdf_cmd_t    push_cmd;
    stdf_cmd_t    pop_cmd;
    logic         push;
    logic         pop;

    stdf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    stdf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    stdf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Reset leaves the output stage empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Every telegram has at least four bytes, so first and last never coincide.
    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && m_tuser && m_tlast))
        else $error("first and last marks on the same byte");

    // The header bytes following the first one are already held in the stage.
    a_header_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser) |=> m_tvalid)
        else $error("header burst interrupted");

endmodule

`default_nettype wire

// File: bench/telegram_stream_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// telegram_stream_checker: scoreboard for the telegram deframer
// Watches both stream channels, runs its own copy of the header search on
// every accepted input byte and compares each output transaction with the
// oldest predicted telegram byte.
// ============================================================================

module telegram_stream_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic       m_tuser,
    input  wire logic       m_tlast,
    output int              mismatch_count,
    output int              pending_beats
);
    import stdf_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } tel_beat_t;

    tel_beat_t         expected_tel_beats[$];
    int                fails = 0;

    logic [7:0]        hunt_win [HDR_BYTES];
    int                hunt_fill;
    bit                in_telegram;
    logic [REM_W-1:0]  body_left;

    task automatic report_mismatch(input string what);
        $display("%0t ns: telegram mismatch, %s", $time, what);
        fails++;
    endtask

    function automatic void clear_deframer();
        foreach (hunt_win[i]) hunt_win[i] = 8'h00;
        hunt_fill   = 0;
        in_telegram = 1'b0;
        body_left   = '0;
    endfunction

    function automatic void push_beat(logic [7:0] d, logic f, logic l);
        tel_beat_t beat;
        beat.data  = d;
        beat.first = f;
        beat.last  = l;
        expected_tel_beats.insert(expected_tel_beats.size(), beat);
    endfunction

    function automatic bit header_in_window();
        bit hit;
        hit = 1'b1;
        for (int i = 0; i < ZERO_BYTES; i++)
            if (hunt_win[i] != 8'h00) hit = 1'b0;
        if (hunt_win[8] != SYNC_B8 || hunt_win[9] != SYNC_B9 || hunt_win[10] != SYNC_B10 ||
            hunt_win[11] != SYNC_B11 || hunt_win[12] != SYNC_B12 || hunt_win[13] != SYNC_B13)
            hit = 1'b0;
        return hit;
    endfunction

    // Works out the telegram bytes that one received byte releases.
    function automatic void deframe_byte(logic [7:0] b);
        int  tel_len;
        logic at_end;
        if (in_telegram) begin
            at_end = (body_left <= 1);
            push_beat(b, 1'b0, at_end);
            if (at_end) begin
                body_left   = '0;
                in_telegram = 1'b0;
            end else begin
                body_left = body_left - 1'b1;
            end
        end else begin
            if (hunt_fill >= HDR_BYTES) begin
                for (int i = 0; i < HDR_BYTES - 1; i++) hunt_win[i] = hunt_win[i+1];
                hunt_fill = HDR_BYTES - 1;
            end
            hunt_win[hunt_fill] = b;
            hunt_fill++;
            if (hunt_fill == HDR_BYTES && header_in_window()) begin
                tel_len = (int'({hunt_win[6], hunt_win[7]}) + 2) * 2;
                if (tel_len >= HDR_BYTES) begin
                    for (int k = 0; k < HDR_BYTES; k++)
                        push_beat(hunt_win[k], k == 0,
                                  k == HDR_BYTES - 1 && tel_len == HDR_BYTES);
                    body_left   = REM_W'(tel_len - HDR_BYTES);
                    in_telegram = (body_left != 0);
                    foreach (hunt_win[i]) hunt_win[i] = 8'h00;
                    hunt_fill = 0;
                end else begin
                    // A short telegram leaves the rest of the window in the search.
                    for (int k = 0; k < tel_len; k++)
                        push_beat(hunt_win[k], k == 0, k == tel_len - 1);
                    for (int i = 0; i < HDR_BYTES - tel_len; i++)
                        hunt_win[i] = hunt_win[i+tel_len];
                    for (int i = HDR_BYTES - tel_len; i < HDR_BYTES; i++)
                        hunt_win[i] = 8'h00;
                    hunt_fill = HDR_BYTES - tel_len;
                end
            end
        end
    endfunction

    always @(posedge aclk) begin : watch
        tel_beat_t want;
        if (!aresetn) begin
            clear_deframer();
            expected_tel_beats.delete();
        end else begin
            // Output first: a byte accepted on s_ at this edge cannot leave yet.
            if (m_tvalid && m_tready) begin
                if (expected_tel_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h", m_tdata));
                end else begin
                    want = expected_tel_beats.pop_front();
                    if (m_tdata != want.data)
                        report_mismatch($sformatf("byte %h, wanted %h", m_tdata, want.data));
                    if (m_tuser != want.first)
                        report_mismatch($sformatf("first mark %b, wanted %b on byte %h",
                                                  m_tuser, want.first, want.data));
                    if (m_tlast != want.last)
                        report_mismatch($sformatf("last mark %b, wanted %b on byte %h",
                                                  m_tlast, want.last, want.data));
                end
            end
            if (s_tvalid && s_tready) deframe_byte(s_tdata);
        end
        pending_beats  <= expected_tel_beats.size();
        mismatch_count <= fails;
    end

endmodule

// File: bench/scanner_telegram_deframer_test.sv
`timescale 1ns / 1ps
// ============================================================================
// scanner_telegram_deframer_test: testbench top of the telegram deframer
// Feeds well-formed, corrupted and overlapping telegram headers, noise and a
// closing telegram with a hidden header through the block under random sender
// gaps and receiver stalls; the checker predicts and compares every output byte.
// ============================================================================

module scanner_telegram_deframer_test;
    import stdf_pkg::*;

    localparam int          CYCLE_LIMIT = 100_000;
    localparam int          TEL_ITEMS   = 410;
    localparam logic [15:0] TAIL_WORD   = 16'd40;
    localparam int          TAIL_BYTES  = (int'(TAIL_WORD) + 2) * 2;

    typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    int         mismatch_count;
    int         pending_beats;
    int         burst_left  = 0;
    int         tel_items   = 0;
    int         cycle_count = 0;
    rx_mode_t   rx_mode     = RX_STREAM;
    int         rx_mode_left = 0;

    scanner_telegram_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    telegram_stream_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver switches at random between stall patterns.
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_t'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(20, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_STREAM: m_tready <= 1'b1;
            RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            RX_TOGGLE: m_tready <= ~m_tready;
            default:   m_tready <= 1'b1;
        endcase
    end

    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        tel_items++;
    endtask

    function automatic logic [7:0] header_byte(int idx, logic [15:0] word);
        case (idx)
            6:       return word[15:8];
            7:       return word[7:0];
            8:       return SYNC_B8;
            9:       return SYNC_B9;
            10:      return SYNC_B10;
            11:      return SYNC_B11;
            12:      return SYNC_B12;
            13:      return SYNC_B13;
            default: return 8'h00;
        endcase
    endfunction

    // Mostly short telegrams, so that many headers and body ends are hit.
    function automatic logic [15:0] pick_length_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 16'($urandom_range(0, 4));
        else if (r < 8)
            return 16'($urandom_range(5, 20));
        else
            return 16'($urandom_range(21, 90));
    endfunction

    // A header followed by its body; optionally a header pattern is hidden in
    // the body, which must pass through untouched.
    task automatic send_telegram(input logic [15:0] word, input bit hide_header);
        int tel_len;
        int body;
        int spot;
        tel_len = (int'(word) + 2) * 2;
        body    = (tel_len > HDR_BYTES) ? tel_len - HDR_BYTES : 0;
        spot    = (hide_header && body >= HDR_BYTES) ? $urandom_range(0, body - HDR_BYTES) : -1;
        for (int i = 0; i < HDR_BYTES; i++) send_byte(header_byte(i, word));
        for (int i = 0; i < body; i++) begin
            if (spot >= 0 && i >= spot && i < spot + HDR_BYTES)
                send_byte(header_byte(i - spot, 16'($urandom_range(0, 4))));
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int         choice;
        int         pos;
        logic [7:0] b;
        logic [15:0] word;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A stray byte so the first header arrives through a full, sliding window;
        // then the shortest telegram, one of exactly header size, and one with a body.
        send_byte(8'hFF);
        send_telegram(16'd0, 1'b0);
        send_telegram(16'd5, 1'b0);
        send_telegram(16'd6, 1'b0);

        // Room is left for the closing telegram within the byte budget.
        while (tel_items + TAIL_BYTES < TEL_ITEMS) begin
            choice = $urandom_range(0, 9);
            word   = pick_length_word();
            if (choice <= 5) begin
                send_telegram(word, $urandom_range(0, 3) == 0);
            end else if (choice == 6) begin
                repeat ($urandom_range(1, 8)) send_byte(8'h00);
                send_telegram(word, 1'b0);
            end else if (choice == 7) begin
                // Corrupt one of the fixed header bytes.
                pos = $urandom_range(0, 11);
                if (pos >= 6) pos += 2;
                for (int i = 0; i < HDR_BYTES; i++) begin
                    b = header_byte(i, word);
                    if (i == pos) b = b ^ 8'($urandom_range(1, 255));
                    send_byte(b);
                end
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end

        // The closing telegram carries a header pattern inside its body.
        send_telegram(TAIL_WORD, 1'b1);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_beats != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
